// ===== rtl/core/dtss_pkg.sv =====
`default_nettype none
package dtss_pkg;

	localparam int MAX_DELIM_LEN = 4;
	localparam int MAX_FIELD_LEN = 64;

	// usable delimiter length: both the sequence registers and the generic cap
	localparam int DELIM_CAP = (MAX_DELIM_LEN < 4) ? MAX_DELIM_LEN : 4;
	localparam int FL_W      = $clog2(MAX_FIELD_LEN);
	localparam logic [FL_W-1:0] FL_MAX = FL_W'(MAX_FIELD_LEN - 1);

	localparam int Q_DEPTH = 4;
	localparam int QPTR_W  = $clog2(Q_DEPTH);
	localparam int QCNT_W  = $clog2(Q_DEPTH + 1);

	localparam int CFG_IDX_W = 8;
	localparam logic [CFG_IDX_W-1:0] CFG_DELIM_LEN  = 8'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_START_DELIM = 8'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_STOP_DELIM  = 8'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_SEPARATOR   = 8'd3;

	localparam logic [2:0]  RST_DELIM_LEN   = 3'd2;
	localparam logic [31:0] RST_START_DELIM = 32'h0000_7B7B;
	localparam logic [31:0] RST_STOP_DELIM  = 32'h0000_7D7D;
	localparam logic [7:0]  RST_SEPARATOR   = 8'h3A;

	typedef enum logic [1:0] {
		KIND_TEXT  = 2'd0,
		KIND_IDENT = 2'd1,
		KIND_PARAM = 2'd2,
		KIND_CLOSE = 2'd3
	} kind_t;

	typedef enum logic [1:0] {
		MODE_TEXT  = 2'd0,
		MODE_IDENT = 2'd1,
		MODE_PARAM = 2'd2
	} mode_t;

	typedef struct packed {
		logic [2:0]  delim_len;
		logic [31:0] start_delim;
		logic [31:0] stop_delim;
		logic [7:0]  separator;
	} cfg_t;

	typedef struct packed {
		logic [7:0] data;
		kind_t      kind;
	} res_t;

	// all results caused by one input byte, in order
	typedef struct packed {
		logic [2:0]       count;
		res_t [3:0]       ent;
	} cmd_t;

	function automatic logic [7:0] seq_byte(input logic [31:0] seq, input logic [1:0] idx);
		seq_byte = seq[idx*8 +: 8];
	endfunction

endpackage
`default_nettype wire

// ===== rtl/core/delimited_tag_stream_scanner.sv =====
`default_nettype none
// Results of an accepted byte pass through the command queue, then the output register.
// Throughput: one input byte per cycle while the queue has room; one result per output
// cycle while out_stall is low; a byte that causes k results (k up to 4) takes k output
// beats; a 4-entry command queue between scanner and serializer absorbs those bursts.
// Reset (arst_n low, asynchronous): scan state cleared, queue empty, registers at
// their default values; no clearing pass, the block accepts bytes right after reset.
module delimited_tag_stream_scanner (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           in_valid,
	output logic                                in_stall,
	input  wire logic [7:0]                     in_byte,
	output logic                                out_valid,
	input  wire logic                           out_stall,
	output logic [7:0]                          out_byte,
	output logic [1:0]                          out_kind,
	output logic                                last_of_run,
	input  wire logic                           cfg_valid,
	output logic                                cfg_ready,
	input  wire logic [dtss_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [31:0]                    cfg_data
);
	import dtss_pkg::*;

	cfg_t cfg_q;
	logic accept;
	logic push, full, head_valid, pop;
	cmd_t push_cmd, head_cmd;

	// register file: always ready, unused indexes dropped
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.delim_len   <= RST_DELIM_LEN;
			cfg_q.start_delim <= RST_START_DELIM;
			cfg_q.stop_delim  <= RST_STOP_DELIM;
			cfg_q.separator   <= RST_SEPARATOR;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_DELIM_LEN:   cfg_q.delim_len   <= cfg_data[2:0];
				CFG_START_DELIM: cfg_q.start_delim <= cfg_data;
				CFG_STOP_DELIM:  cfg_q.stop_delim  <= cfg_data;
				CFG_SEPARATOR:   cfg_q.separator   <= cfg_data[7:0];
				default: begin
				end
			endcase
		end
	end

	// front takes a byte whenever the queue has room; stall comes only from queue state
	assign in_stall = full;
	assign accept   = in_valid && !in_stall;

	dtss_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.accept   (accept),
		.in_byte  (in_byte),
		.push     (push),
		.push_cmd (push_cmd)
	);

	dtss_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_cmd   (push_cmd),
		.full       (full),
		.head_valid (head_valid),
		.head_cmd   (head_cmd),
		.pop        (pop)
	);

	// back serializes each command, one result per output cycle while out_stall is low
	dtss_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.head_valid  (head_valid),
		.head_cmd    (head_cmd),
		.pop         (pop),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.out_byte    (out_byte),
		.out_kind    (out_kind),
		.last_of_run (last_of_run)
	);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_byte) && $stable(out_kind))
		else $error("stalled result changed");

endmodule
`default_nettype wire

// ===== rtl/core/dtss_front.sv =====
`default_nettype none
module dtss_front (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire dtss_pkg::cfg_t cfg,
	input  wire logic          accept,
	input  wire logic [7:0]    in_byte,
	output logic               push,
	output dtss_pkg::cmd_t     push_cmd
);
	import dtss_pkg::*;

	logic            inside_q, inside_d;
	logic [1:0]      mc_q, mc_d;
	mode_t           mode_q, mode_d;
	logic [FL_W-1:0] fl_q, fl_d;

	logic [2:0] len;
	logic [2:0] mc_inc;
	logic       done;
	logic       start_hit, stop_hit;
	kind_t      fkind;
	cmd_t       cmd;

	always_comb begin
		if (cfg.delim_len == 3'd0) begin
			len = 3'd1;
		end else if (cfg.delim_len > 3'(DELIM_CAP)) begin
			len = 3'(DELIM_CAP);
		end else begin
			len = cfg.delim_len;
		end
	end

	always_comb begin
		mc_inc    = {1'b0, mc_q} + 3'd1;
		done      = mc_inc >= len;
		start_hit = !inside_q && (in_byte == seq_byte(cfg.start_delim, mc_q));
		stop_hit  = inside_q && (in_byte == seq_byte(cfg.stop_delim, mc_q));
		fkind     = (mode_q == MODE_PARAM) ? KIND_PARAM : KIND_IDENT;

		inside_d = inside_q;
		mc_d     = mc_q;
		mode_d   = mode_q;
		fl_d     = fl_q;
		cmd      = '0;

		if (start_hit) begin
			if (done) begin
				inside_d = 1'b1;
				mc_d     = 2'd0;
				mode_d   = MODE_IDENT;
				fl_d     = '0;
			end else begin
				mc_d = mc_inc[1:0];
			end
		end else if (stop_hit) begin
			if (done) begin
				cmd.ent[0] = '{data: 8'h00, kind: KIND_CLOSE};
				cmd.count  = 3'd1;
				inside_d   = 1'b0;
				mc_d       = 2'd0;
				mode_d     = MODE_TEXT;
				fl_d       = '0;
			end else begin
				mc_d = mc_inc[1:0];
			end
		end else begin
			// flush the partial delimiter match
			for (int i = 0; i < 3; i++) begin
				if (2'(i) < mc_q) begin
					if (!inside_q) begin
						cmd.ent[cmd.count[1:0]] =
							'{data: seq_byte(cfg.start_delim, 2'(i)), kind: KIND_TEXT};
						cmd.count = cmd.count + 3'd1;
					end else if (fl_d < FL_MAX) begin
						fl_d = fl_d + 1'b1;
						cmd.ent[cmd.count[1:0]] =
							'{data: seq_byte(cfg.stop_delim, 2'(i)), kind: fkind};
						cmd.count = cmd.count + 3'd1;
					end
				end
			end
			mc_d = 2'd0;
			if (!inside_q) begin
				cmd.ent[cmd.count[1:0]] = '{data: in_byte, kind: KIND_TEXT};
				cmd.count = cmd.count + 3'd1;
			end else if (mode_q == MODE_IDENT && in_byte == cfg.separator) begin
				mode_d = MODE_PARAM;
				fl_d   = '0;
			end else if (fl_d < FL_MAX) begin
				fl_d = fl_d + 1'b1;
				cmd.ent[cmd.count[1:0]] = '{data: in_byte, kind: fkind};
				cmd.count = cmd.count + 3'd1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inside_q <= 1'b0;
			mc_q     <= 2'd0;
			mode_q   <= MODE_TEXT;
			fl_q     <= '0;
		end else if (accept) begin
			inside_q <= inside_d;
			mc_q     <= mc_d;
			mode_q   <= mode_d;
			fl_q     <= fl_d;
		end
	end

	assign push     = accept && (cmd.count != 3'd0);
	assign push_cmd = cmd;

	a_mode_text_outside: assert property (@(posedge clk) disable iff (!arst_n)
		inside_q == (mode_q != MODE_TEXT))
		else $error("field mode disagrees with tag state");
	a_match_below_cap: assert property (@(posedge clk) disable iff (!arst_n)
		{1'b0, mc_q} < 3'(DELIM_CAP))
		else $error("delimiter match count reached its cap");
	a_field_sat: assert property (@(posedge clk) disable iff (!arst_n)
		accept && inside_q && (fl_q == FL_MAX) && !stop_hit && (mc_q == 2'd0) |=> fl_q == FL_MAX
			|| !inside_q || mode_q == MODE_PARAM)
		else $error("full field length moved");

endmodule
`default_nettype wire

// ===== rtl/core/dtss_queue.sv =====
`default_nettype none
module dtss_queue (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           push,
	input  wire dtss_pkg::cmd_t push_cmd,
	output logic                full,
	output logic                head_valid,
	output dtss_pkg::cmd_t      head_cmd,
	input  wire logic           pop
);
	import dtss_pkg::*;

	cmd_t              mem_q [Q_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [QCNT_W-1:0] count_q;

	assign full       = count_q == QCNT_W'(Q_DEPTH);
	assign head_valid = count_q != '0;
	assign head_cmd   = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		full |-> !push)
		else $error("push into full queue");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> head_valid)
		else $error("pop from empty queue");

endmodule
`default_nettype wire

// ===== rtl/core/dtss_back.sv =====
`default_nettype none
module dtss_back (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           head_valid,
	input  wire dtss_pkg::cmd_t head_cmd,
	output logic                pop,
	output logic                out_valid,
	input  wire logic           out_stall,
	output logic [7:0]          out_byte,
	output logic [1:0]          out_kind,
	output logic                last_of_run
);
	import dtss_pkg::*;

	logic [1:0] idx_q;
	logic       valid_q;
	logic [7:0] byte_q;
	kind_t      kind_q;
	logic       last_q;
	logic       load;
	logic       last;

	assign load = head_valid && (!valid_q || !out_stall);
	assign last = {1'b0, idx_q} == (head_cmd.count - 3'd1);
	assign pop  = load && last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			idx_q   <= 2'd0;
		end else begin
			if (!valid_q || !out_stall) begin
				valid_q <= head_valid;
			end
			if (load) begin
				idx_q <= last ? 2'd0 : idx_q + 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			byte_q <= head_cmd.ent[idx_q].data;
			kind_q <= head_cmd.ent[idx_q].kind;
			last_q <= last;
		end
	end

	assign out_valid   = valid_q;
	assign out_byte    = byte_q;
	assign out_kind    = kind_q;
	assign last_of_run = last_q;

	a_idx_in_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		head_valid |-> {1'b0, idx_q} < head_cmd.count)
		else $error("result index beyond command");
	a_close_alone: assert property (@(posedge clk) disable iff (!arst_n)
		valid_q && kind_q == KIND_CLOSE |-> last_q && byte_q == 8'h00)
		else $error("close marker not alone");

endmodule
`default_nettype wire

// ===== verif/delimited_tag_stream_scanner_tb.sv =====
`timescale 1ns / 100ps
module delimited_tag_stream_scanner_tb;
	import dtss_pkg::*;

	localparam int QUIET_LIMIT = 3000;  // cycles with no handshake at all
	localparam int HOLD_CYCLES = 400;   // long receiver hold-off
	localparam int SETTLE_CYCLES = 8;   // covers the path through the queue and the output register
	localparam int RANDOM_ITEMS = 240;

	// one expected output beat
	typedef struct packed {
		logic [7:0] data;
		kind_t      kind;
		logic       last;
	} scan_result_t;

	logic                 clk = 1'b0;
	logic                 arst_n;
	logic                 in_valid;
	logic                 in_stall;
	logic [7:0]           in_byte;
	logic                 out_valid;
	logic                 out_stall;
	logic [7:0]           out_byte;
	logic [1:0]           out_kind;
	logic                 last_of_run;
	logic                 cfg_valid;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [31:0]          cfg_data;

	delimited_tag_stream_scanner i_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.in_byte    (in_byte),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.out_byte   (out_byte),
		.out_kind   (out_kind),
		.last_of_run(last_of_run),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data)
	);

	always #1 clk = ~clk;

	// ------------------------------------------------------------------
	// Shadow of the register file and of the scan state
	// ------------------------------------------------------------------
	logic [2:0]  sh_len   = RST_DELIM_LEN;
	logic [31:0] sh_start = RST_START_DELIM;
	logic [31:0] sh_stop  = RST_STOP_DELIM;
	logic [7:0]  sh_sep   = RST_SEPARATOR;

	bit    st_inside  = 1'b0;
	int    st_matched = 0;
	mode_t st_mode    = MODE_TEXT;
	int    st_flen    = 0;

	scan_result_t pending_results[$];  // expected beats, oldest first
	scan_result_t byte_results[$];     // beats caused by the byte being scanned

	int  mismatches = 0;
	int  items_sent = 0;
	int  burst_left = 0;
	bit  hold_req   = 1'b0;

	// length 0 behaves as 1, anything above the cap saturates
	function automatic int delim_len_eff();
		int n;
		n = sh_len;
		if (n == 0) n = 1;
		if (n > DELIM_CAP) n = DELIM_CAP;
		return n;
	endfunction

	function automatic logic [7:0] delim_byte(input logic [31:0] seq, input int idx);
		if (idx >= 4) return 8'h00;
		return seq[idx*8 +: 8];
	endfunction

	function automatic void emit_beat(input logic [7:0] b, input kind_t k);
		scan_result_t r;
		if (byte_results.size() >= 4) return;
		r.data = b;
		r.kind = k;
		r.last = 1'b0;
		byte_results.push_back(r);
	endfunction

	// field bytes past MAX_FIELD_LEN-1 are silently dropped
	function automatic void append_field(input logic [7:0] b);
		if (st_flen < MAX_FIELD_LEN - 1) begin
			st_flen++;
			emit_beat(b, (st_mode == MODE_PARAM) ? KIND_PARAM : KIND_IDENT);
		end
	endfunction

	// advance the scan state by one accepted byte and queue what it produces
	function automatic void scan_byte(input logic [7:0] b);
		int len;
		len = delim_len_eff();
		byte_results.delete();
		if (!st_inside && b == delim_byte(sh_start, st_matched)) begin
			st_matched++;
			if (st_matched >= len) begin
				st_inside  = 1'b1;
				st_matched = 0;
				st_mode    = MODE_IDENT;
				st_flen    = 0;
			end
		end else if (st_inside && b == delim_byte(sh_stop, st_matched)) begin
			st_matched++;
			if (st_matched >= len) begin
				emit_beat(8'h00, KIND_CLOSE);
				st_inside  = 1'b0;
				st_matched = 0;
				st_mode    = MODE_TEXT;
				st_flen    = 0;
			end
		end else begin
			// broken delimiter: replay the matched prefix
			for (int i = 0; i < st_matched && i < 4; i++) begin
				if (!st_inside)
					emit_beat(delim_byte(sh_start, i), KIND_TEXT);
				else
					append_field(delim_byte(sh_stop, i));
			end
			st_matched = 0;
			if (!st_inside) begin
				emit_beat(b, KIND_TEXT);
			end else if (st_mode == MODE_IDENT && b == sh_sep) begin
				st_mode = MODE_PARAM;
				st_flen = 0;
			end else begin
				append_field(b);
			end
		end
		if (byte_results.size() > 0)
			byte_results[byte_results.size()-1].last = 1'b1;
		foreach (byte_results[i])
			pending_results.push_back(byte_results[i]);
	endfunction

	// ------------------------------------------------------------------
	// Drivers. Every task is entered and left at a falling edge.
	// ------------------------------------------------------------------
	task automatic send_byte(input logic [7:0] b);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			burst_left = $urandom_range(1, 24);
		end
		in_valid <= 1'b1;
		in_byte  <= b;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		scan_byte(b);
		items_sent++;
		burst_left--;
		@(negedge clk);
	endtask

	task automatic send_text(input string s);
		for (int i = 0; i < s.len(); i++) send_byte(s[i]);
	endtask

	task automatic send_seq(input logic [31:0] seq, input int n);
		for (int i = 0; i < n; i++) send_byte(delim_byte(seq, i));
	endtask

	// sender pauses until every expected beat has come back
	task automatic settle();
		in_valid <= 1'b0;
		burst_left = 0;
		while (pending_results.size() != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	// leaves cfg_valid high so back-to-back writes never toggle it in one step
	task automatic reg_write(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		case (idx)
			CFG_DELIM_LEN:   sh_len   = data[2:0];
			CFG_START_DELIM: sh_start = data;
			CFG_STOP_DELIM:  sh_stop  = data;
			CFG_SEPARATOR:   sh_sep   = data[7:0];
			default: ;
		endcase
		@(negedge clk);
	endtask

	// upper bits of the narrow registers carry junk that must be ignored
	task automatic program_regs(input logic [2:0] len, input logic [31:0] start,
			input logic [31:0] stop, input logic [7:0] sep, input logic [CFG_IDX_W-1:0] spare);
		reg_write(CFG_DELIM_LEN, {$urandom} & ~32'h7 | 32'(len));
		reg_write(CFG_START_DELIM, start);
		reg_write(CFG_STOP_DELIM, stop);
		reg_write(CFG_SEPARATOR, {$urandom} & ~32'hFF | 32'(sep));
		reg_write(spare, $urandom);
		cfg_valid <= 1'b0;
	endtask

	// ------------------------------------------------------------------
	// Stimulus helpers
	// ------------------------------------------------------------------
	// biased toward delimiter and separator bytes so matches break often
	function automatic logic [7:0] pick_byte();
		int n;
		n = delim_len_eff();
		case ($urandom_range(0, 9))
			0, 1, 2, 3: return 8'($urandom);
			4, 5:       return delim_byte(sh_start, $urandom_range(0, n - 1));
			6, 7:       return delim_byte(sh_stop, $urandom_range(0, n - 1));
			8:          return sh_sep;
			default:    return 8'($urandom_range(8'h61, 8'h7A));
		endcase
	endfunction

	// field byte that neither starts a stop match nor switches to the parameter
	function automatic logic [7:0] plain_byte();
		logic [7:0] b;
		do b = 8'($urandom); while (b == delim_byte(sh_stop, 0) || b == sh_sep);
		return b;
	endfunction

	// all but the last stop byte, then a mismatch: up to four beats at once
	task automatic broken_stop();
		int k;
		logic [7:0] b;
		k = delim_len_eff() - 1;
		send_seq(sh_stop, k);
		do b = 8'($urandom); while (b == delim_byte(sh_stop, k) || b == sh_sep);
		send_byte(b);
	endtask

	// walk the scanner back to plain text with no partial match
	task automatic reach_text();
		while (st_inside || st_matched != 0) begin
			if (st_inside)
				send_byte(delim_byte(sh_stop, st_matched));
			else
				send_byte(~delim_byte(sh_start, st_matched));
		end
	endtask

	task automatic send_tag_segment();
		int n;
		n = delim_len_eff();
		repeat ($urandom_range(0, 4)) send_byte(pick_byte());
		send_seq(sh_start, n);
		repeat ($urandom_range(0, 6)) send_byte(pick_byte());
		if ($urandom_range(0, 2) != 0) begin
			send_byte(sh_sep);
			repeat ($urandom_range(0, 6)) send_byte(pick_byte());
		end
		if ($urandom_range(0, 2) == 0) broken_stop();
		send_seq(sh_stop, n);
	endtask

	task automatic send_noise_segment();
		repeat ($urandom_range(1, 6)) send_byte(pick_byte());
		send_seq(sh_start, $urandom_range(0, delim_len_eff() - 1));
		send_byte(pick_byte());
	endtask

	// delimiter bytes from a two-letter alphabet, so sequences overlap themselves
	function automatic logic [31:0] overlapping_delim();
		logic [7:0]  a;
		logic [7:0]  b;
		logic [31:0] seq;
		a = 8'($urandom);
		b = 8'($urandom);
		for (int i = 0; i < 4; i++) seq[i*8 +: 8] = $urandom_range(0, 1) ? a : b;
		return seq;
	endfunction

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------
	// plain text, including both byte extremes
	task automatic test_text_extremes();
		send_byte(8'h00);
		send_byte(8'hFF);
		send_text("A");
	endtask

	// full tag with identifier, parameter and a second separator in the parameter
	task automatic test_basic_tag();
		send_text("{{id:p:q}}");
	endtask

	// start match broken by the second byte: prefix replays as text
	task automatic test_broken_start();
		send_text("{x");
	endtask

	// stop match broken by a field byte and by the separator
	task automatic test_broken_stop();
		send_text("{{a}b}}");
		send_text("{{a}:b}}");
	endtask

	// registers change while a start match is half done, length 0 acts as 1
	task automatic test_write_mid_match();
		send_text("{");
		settle();
		program_regs(3'd0, RST_START_DELIM, RST_STOP_DELIM, RST_SEPARATOR,
			CFG_IDX_W'((1 << CFG_IDX_W) - 1));
		send_text("{z}");
	endtask

	// receiver holds off long enough for the block to stall its input
	task automatic test_backpressure();
		hold_req = 1'b1;
		repeat (30) send_byte(pick_byte());
		settle();
	endtask

	// random phases with fresh settings; one phase carries overflowing fields
	task automatic test_random_stream();
		int phase;
		int target;
		logic [2:0]  len;
		logic [31:0] start;
		logic [31:0] stop;
		logic [7:0]  sep;
		phase  = 0;
		target = items_sent + RANDOM_ITEMS;
		while (items_sent < target) begin
			settle();
			case (phase)
				0: begin len = 3'd4; start = '1; stop = '0; sep = 8'hFF; end
				1: begin len = 3'd7; start = '0; stop = '1; sep = 8'($urandom); end
				2: begin len = 3'd3; start = overlapping_delim(); stop = overlapping_delim();
					sep = 8'($urandom); end
				3: begin len = 3'd1; start = overlapping_delim(); stop = overlapping_delim();
					sep = 8'h00; end
				default: begin len = 3'($urandom_range(0, 7)); start = overlapping_delim();
					stop = overlapping_delim(); sep = 8'($urandom); end
			endcase
			program_regs(len, start, stop, sep,
				CFG_IDX_W'($urandom_range(CFG_SEPARATOR + 1, 255)));
			if (phase == 0) begin
				// both fields overrun, with stop prefixes replayed into full fields
				reach_text();
				send_seq(sh_start, delim_len_eff());
				repeat (MAX_FIELD_LEN + 2) send_byte(plain_byte());
				broken_stop();
				send_byte(sh_sep);
				repeat (MAX_FIELD_LEN + 2) send_byte(plain_byte());
				broken_stop();
				send_seq(sh_stop, delim_len_eff());
			end
			repeat ($urandom_range(4, 8)) begin
				if (items_sent < target) begin
					if ($urandom_range(0, 9) < 7)
						send_tag_segment();
					else
						send_noise_segment();
				end
			end
			phase++;
		end
	endtask

	// ------------------------------------------------------------------
	// Receiver stall pattern: a random style for a random stretch,
	// with long hold-offs on request
	// ------------------------------------------------------------------
	int stall_style = 0;
	int style_left  = 0;
	int hold_left   = 0;

	always @(negedge clk) begin
		if (hold_left > 0) begin
			out_stall <= 1'b1;
			hold_left--;
		end else if (hold_req) begin
			hold_req = 1'b0;
			hold_left = HOLD_CYCLES - 1;
			out_stall <= 1'b1;
		end else begin
			if (style_left == 0) begin
				stall_style = $urandom_range(0, 3);
				style_left  = $urandom_range(8, 60);
			end
			style_left--;
			case (stall_style)
				0: out_stall <= 1'b0;
				1: out_stall <= ($urandom_range(0, 3) == 0);
				2: out_stall <= ($urandom_range(0, 3) != 0);
				default: out_stall <= ~out_stall;
			endcase
		end
	end

	// ------------------------------------------------------------------
	// Result checker
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		scan_result_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_results.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected beat: byte %02h kind %0d last %0b",
						out_byte, out_kind, last_of_run);
			end else begin
				want = pending_results.pop_front();
				if (out_byte !== want.data || out_kind !== want.kind
						|| last_of_run !== want.last) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: expected byte %02h kind %0d last %0b, got %02h %0d %0b",
							want.data, want.kind, want.last, out_byte, out_kind, last_of_run);
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// Watchdog: any handshake counts as progress
	// ------------------------------------------------------------------
	int quiet_cycles = 0;

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= QUIET_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// ------------------------------------------------------------------
	// Main sequence
	// ------------------------------------------------------------------
	initial begin
		arst_n    = 1'b0;
		in_valid  = 1'b0;
		in_byte   = 8'h00;
		out_stall = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data  = '0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		test_text_extremes();
		test_basic_tag();
		test_broken_start();
		test_broken_stop();
		test_write_mid_match();
		test_backpressure();
		test_random_stream();

		settle();
		repeat (20) @(posedge clk);
		if (mismatches == 0 && pending_results.size() == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
